// ===== rtl/lcdnw_pkg.sv =====
// Shared types, constants and init tables for the character LCD nibble writer.
`timescale 1ns / 1ps
package lcdnw_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam int HOLD_W     = 17;
  localparam int INIT_COUNT = 7;
  localparam int INIT_IDX_W = 3;
  localparam int PHASE_W    = 3;

  localparam logic [HOLD_W-1:0] BYTE_HOLD_US    = 17'd40;
  localparam logic [HOLD_W-1:0] POWERUP_WAIT_US = 17'd10000;

  localparam logic [INIT_IDX_W-1:0] INIT_LAST_IDX = 3'(INIT_COUNT - 1);
  localparam logic [PHASE_W-1:0]    PHASE_LAST    = 3'd4;

  typedef enum logic [1:0] {
    OP_CMD    = 2'd0,
    OP_DATA   = 2'd1,
    OP_CURSOR = 2'd2,
    OP_INIT   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_BYTE
  } seq_state_t;

  // One queued job: either a single byte write or the whole power-up run.
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] cmd;
  } job_t;

  function automatic logic [7:0] init_cmd(input logic [INIT_IDX_W-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h33;
      3'd1:    c = 8'h32;
      3'd2:    c = 8'h28;
      3'd3:    c = 8'h06;
      3'd4:    c = 8'h0C;
      3'd5:    c = 8'h01;
      3'd6:    c = 8'h80;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Byte hold (40 us) plus the extra settle time of each init command.
  function automatic logic [HOLD_W-1:0] init_hold(input logic [INIT_IDX_W-1:0] idx);
    logic [HOLD_W-1:0] h;
    unique case (idx)
      3'd0:    h = 17'd41040;
      3'd1:    h = 17'd100040;
      3'd2:    h = 17'd50040;
      3'd3:    h = 17'd50040;
      3'd4:    h = 17'd1040;
      3'd5:    h = 17'd1040;
      3'd6:    h = 17'd1040;
      default: h = BYTE_HOLD_US;
    endcase
    return h;
  endfunction

endpackage

// ===== rtl/lcdnw_front.sv =====
// Front end: takes request words and turns them into queued jobs.
`timescale 1ns / 1ps
module lcdnw_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_op,
  input  logic [15:0]      in_data,
  output logic             job_valid,
  input  logic             job_ready,
  output lcdnw_pkg::job_t  job
);

  lcdnw_pkg::job_t job_next;
  logic [7:0]      value;
  logic [3:0]      column;
  logic            row;

  assign value    = in_data[7:0];
  assign column   = in_data[11:8];
  assign row      = in_data[12];
  assign in_ready = !job_valid || job_ready;

  always_comb begin
    job_next = '0;
    unique case (lcdnw_pkg::op_t'(in_op))
      lcdnw_pkg::OP_CMD: begin
        job_next.cmd = value;
      end
      lcdnw_pkg::OP_DATA: begin
        job_next.rs  = 1'b1;
        job_next.cmd = value;
      end
      lcdnw_pkg::OP_CURSOR: begin
        // 0x80 + column, or 0xC0 + column on the second line
        job_next.cmd = {1'b1, row, 2'b00, column};
      end
      lcdnw_pkg::OP_INIT: begin
        job_next.is_init = 1'b1;
      end
      default: job_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (in_ready) begin
      job_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      job <= job_next;
    end
  end

endmodule

// ===== rtl/lcdnw_fifo.sv =====
// Short job queue between the front end and the pin sequencer.
`timescale 1ns / 1ps
module lcdnw_fifo #(
  parameter int DEPTH = lcdnw_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  lcdnw_pkg::job_t push_job,
  output logic            pop_valid,
  input  logic            pop_ready,
  output lcdnw_pkg::job_t pop_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lcdnw_pkg::job_t mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_job    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/lcdnw_back.sv =====
// Back end: walks each job through its pin states into the output register.
`timescale 1ns / 1ps
module lcdnw_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  output logic            job_ready,
  input  lcdnw_pkg::job_t job,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [23:0]     out_data,
  output logic            out_last
);

  lcdnw_pkg::seq_state_t                 state, state_next;
  logic [lcdnw_pkg::PHASE_W-1:0]         phase, phase_next;
  logic [lcdnw_pkg::INIT_IDX_W-1:0]      idx, idx_next;
  logic                                  init_mode, init_mode_next;
  logic [7:0]                            cur_byte, cur_byte_next;
  logic                                  cur_rs, cur_rs_next;
  logic [3:0]                            data_lines, data_lines_next;
  logic                                  out_valid_next;
  logic [23:0]                           out_data_next;
  logic                                  out_last_next;
  logic                                  slot_free;
  logic [3:0]                            hi_nib;
  logic [3:0]                            lo_nib;
  logic [lcdnw_pkg::HOLD_W-1:0]          end_hold;
  logic                                  end_last;

  assign slot_free = !out_valid || out_ready;
  assign hi_nib    = cur_byte[7:4];
  assign lo_nib    = cur_byte[3:0];
  assign end_hold  = init_mode ? lcdnw_pkg::init_hold(idx) : lcdnw_pkg::BYTE_HOLD_US;
  assign end_last  = !init_mode || (idx == lcdnw_pkg::INIT_LAST_IDX);

  // out_data: {hold_us, enable, read_write, reg_select, data_nibble}
  always_comb begin
    state_next      = state;
    phase_next      = phase;
    idx_next        = idx;
    init_mode_next  = init_mode;
    cur_byte_next   = cur_byte;
    cur_rs_next     = cur_rs;
    data_lines_next = data_lines;
    out_valid_next  = out_valid && !out_ready;
    out_data_next   = out_data;
    out_last_next   = out_last;
    job_ready       = 1'b0;

    unique case (state)
      lcdnw_pkg::ST_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          phase_next = '0;
          idx_next   = '0;
          if (job.is_init) begin
            state_next = lcdnw_pkg::ST_WAIT;
          end else begin
            state_next     = lcdnw_pkg::ST_BYTE;
            init_mode_next = 1'b0;
            cur_byte_next  = job.cmd;
            cur_rs_next    = job.rs;
          end
        end
      end
      lcdnw_pkg::ST_WAIT: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_data_next  = {lcdnw_pkg::POWERUP_WAIT_US, 1'b0, 1'b1, 1'b1, data_lines};
          out_last_next  = 1'b0;
          state_next     = lcdnw_pkg::ST_BYTE;
          init_mode_next = 1'b1;
          cur_byte_next  = lcdnw_pkg::init_cmd(idx);
          cur_rs_next    = 1'b0;
        end
      end
      lcdnw_pkg::ST_BYTE: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_last_next  = 1'b0;
          phase_next     = phase + 1'b1;
          unique case (phase)
            3'd0:    out_data_next = {17'd0, 1'b1, 1'b0, cur_rs, hi_nib};
            3'd1:    out_data_next = {17'd0, 1'b0, 1'b0, cur_rs, hi_nib};
            3'd2:    out_data_next = {17'd0, 1'b1, 1'b0, cur_rs, lo_nib};
            3'd3:    out_data_next = {17'd0, 1'b0, 1'b0, cur_rs, lo_nib};
            default: out_data_next = {end_hold, 1'b0, 1'b1, 1'b1, lo_nib};
          endcase
          if (phase == lcdnw_pkg::PHASE_LAST) begin
            out_last_next   = end_last;
            data_lines_next = lo_nib;
            phase_next      = '0;
            if (end_last) begin
              state_next = lcdnw_pkg::ST_IDLE;
            end else begin
              idx_next      = idx + 1'b1;
              cur_byte_next = lcdnw_pkg::init_cmd(idx + 1'b1);
            end
          end
        end
      end
      default: state_next = lcdnw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lcdnw_pkg::ST_IDLE;
      phase      <= '0;
      idx        <= '0;
      init_mode  <= 1'b0;
      data_lines <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      idx        <= idx_next;
      init_mode  <= init_mode_next;
      data_lines <= data_lines_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_byte <= cur_byte_next;
    cur_rs   <= cur_rs_next;
    out_data <= out_data_next;
    out_last <= out_last_next;
  end

endmodule

// ===== rtl/char_lcd_nibble_writer_core.sv =====
// Top level of the character LCD 4-bit nibble writer.
`timescale 1ns / 1ps
// Channel   Dir  Width      Contents
// s_axis    in   16 + 2     request word: tdata value/column/row, tuser op
// m_axis    out  24 + 1     pin state word: tdata pins and hold, tlast end of request
//
// A byte request (command, data, cursor) gives five pin states, one per cycle
// when the sink is ready. Power-up gives 36 pin states.
// The front stage and a short job queue keep taking requests while the
// sequencer works or the sink stalls; the output register holds under stall.
// Synchronous reset clears all control state and the held data lines to zero.
module char_lcd_nibble_writer_core #(
  parameter int QUEUE_DEPTH = lcdnw_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] value, [11:8] column, [12] row, rest zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] data_nibble, [4] reg_select, [5] read_write, [6] enable, [23:7] hold_us
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast    // last pin state of the request
);

  lcdnw_pkg::job_t front_job;
  lcdnw_pkg::job_t queue_job;
  logic            front_valid;
  logic            front_ready;
  logic            queue_valid;
  logic            queue_ready;

  // Decode op into a job word.
  lcdnw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .job_valid (front_valid),
    .job_ready (front_ready),
    .job       (front_job)
  );

  lcdnw_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_job   (front_job),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_job    (queue_job)
  );

  // Pin sequencer owns the held data lines and the output register.
  lcdnw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (queue_valid),
    .job_ready (queue_ready),
    .job       (queue_job),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

// ===== rtl/lcdnw_checker.sv =====
// Port-level checks for the character LCD nibble writer, bound to the top level.
`timescale 1ns / 1ps
module lcdnw_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed under stall");

  a_strobe_write: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[6] |->
      !m_axis_tdata[5] && (m_axis_tdata[23:7] == 17'd0))
    else $error("enable strobe outside a zero-hold write state");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |->
      !m_axis_tdata[6] && m_axis_tdata[5] && m_axis_tdata[4])
    else $error("final state not at idle control levels");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[5] |-> (m_axis_tdata[23:7] != 17'd0))
    else $error("idle state without hold time");

endmodule

bind char_lcd_nibble_writer_core lcdnw_checker u_lcdnw_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/char_lcd_nibble_writer_core_test.sv =====
// Self-checking testbench for the character LCD 4-bit nibble writer.
`timescale 1ns / 1ps
module char_lcd_nibble_writer_core_test;

  // Pin state timing and command encodings of the 4-bit LCD protocol.
  localparam logic [16:0] SETTLE_US      = 17'd40;
  localparam logic [16:0] POWER_WAIT_US  = 17'd10000;
  localparam logic [7:0]  CURSOR_LINE0   = 8'h80;
  localparam logic [7:0]  CURSOR_LINE1   = 8'hC0;
  localparam int          POWER_CMD_CNT  = 7;
  // Power-up command list and the extra settle time of each, entry 0 first.
  localparam logic [6:0][7:0] POWER_CMDS =
    {8'h80, 8'h01, 8'h0C, 8'h06, 8'h28, 8'h32, 8'h33};
  localparam logic [6:0][16:0] POWER_EXTRA_US =
    {17'd1000, 17'd1000, 17'd1000, 17'd50000, 17'd50000, 17'd100000, 17'd41000};

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 24;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [3:0]  nibble;
    logic        rs;
    logic        rw;
    logic        en;
    logic [16:0] hold;
    logic        last;
  } pin_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  pin_state_t pin_states_due[$];
  logic [3:0] held_nibble;
  int         send_idle_pct;
  int         sink_stall_pct;
  int         error_count;
  int         pins_checked;
  int         cycle_count;
  int         op_count[4];
  pin_state_t got_pin;
  pin_state_t want_pin;

  char_lcd_nibble_writer_core DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Pin state prediction
  // ---------------------------------------------------------------------

  // One byte: high nibble strobe, low nibble strobe, then idle lines + hold.
  function automatic void predict_byte(logic [7:0] byte_val, logic rs,
                                       logic [16:0] extra_us, logic is_final);
    logic [3:0] hi;
    logic [3:0] lo;
    hi = byte_val[7:4];
    lo = byte_val[3:0];
    pin_states_due.push_back('{hi, rs, 1'b0, 1'b1, 17'd0, 1'b0});
    pin_states_due.push_back('{hi, rs, 1'b0, 1'b0, 17'd0, 1'b0});
    pin_states_due.push_back('{lo, rs, 1'b0, 1'b1, 17'd0, 1'b0});
    pin_states_due.push_back('{lo, rs, 1'b0, 1'b0, 17'd0, 1'b0});
    pin_states_due.push_back('{lo, 1'b1, 1'b1, 1'b0, SETTLE_US + extra_us, is_final});
    held_nibble = lo;
  endfunction

  function automatic void predict_request(lcdnw_pkg::op_t op, logic [7:0] value,
                                          logic [3:0] column, logic row);
    op_count[op]++;
    case (op)
      lcdnw_pkg::OP_CMD:    predict_byte(value, 1'b0, 17'd0, 1'b1);
      lcdnw_pkg::OP_DATA:   predict_byte(value, 1'b1, 17'd0, 1'b1);
      lcdnw_pkg::OP_CURSOR: predict_byte((row ? CURSOR_LINE1 : CURSOR_LINE0) + {4'd0, column},
                                         1'b0, 17'd0, 1'b1);
      default: begin
        // Power-up: long wait with the lines as last driven, then the init list.
        pin_states_due.push_back('{held_nibble, 1'b1, 1'b1, 1'b0, POWER_WAIT_US, 1'b0});
        for (int i = 0; i < POWER_CMD_CNT; i++)
          predict_byte(POWER_CMDS[i], 1'b0, POWER_EXTRA_US[i], i == POWER_CMD_CNT - 1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  // Called just after a falling edge; returns just after a falling edge.
  // tvalid is left high so back-to-back words need no second assignment.
  task automatic send_request(lcdnw_pkg::op_t op, logic [7:0] value, logic [3:0] column,
                              logic row);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, row, column, value};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    predict_request(op, value, column, row);
    @(negedge clk);
  endtask

  // Hold the request side quiet until every predicted pin state has come out.
  task automatic drain_pin_states();
    s_axis_tvalid <= 1'b0;
    while (pin_states_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_request();
    lcdnw_pkg::op_t op;
    if ($urandom_range(99) < 8) op = lcdnw_pkg::OP_INIT;
    else op = lcdnw_pkg::op_t'($urandom_range(2));
    send_request(op, 8'($urandom), 4'($urandom), 1'($urandom));
  endtask

  // ---------------------------------------------------------------------
  // Sink side and checking
  // ---------------------------------------------------------------------

  always @(negedge clk)
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

  function automatic void report_mismatch(string field, int want, int got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("pin state %0d: %s expected %0d, got %0d", pins_checked, field, want, got);
  endfunction

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_pin = '{m_axis_tdata[3:0], m_axis_tdata[4], m_axis_tdata[5], m_axis_tdata[6],
                  m_axis_tdata[23:7], m_axis_tlast};
      if (pin_states_due.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("pin state %0d: unexpected word %h last %b",
                   pins_checked, m_axis_tdata, m_axis_tlast);
      end else begin
        want_pin = pin_states_due.pop_front();
        if (got_pin.nibble != want_pin.nibble)
          report_mismatch("data_nibble", want_pin.nibble, got_pin.nibble);
        if (got_pin.rs != want_pin.rs)
          report_mismatch("reg_select", want_pin.rs, got_pin.rs);
        if (got_pin.rw != want_pin.rw)
          report_mismatch("read_write", want_pin.rw, got_pin.rw);
        if (got_pin.en != want_pin.en)
          report_mismatch("enable", want_pin.en, got_pin.en);
        if (got_pin.hold != want_pin.hold)
          report_mismatch("hold_us", want_pin.hold, got_pin.hold);
        if (got_pin.last != want_pin.last)
          report_mismatch("last", want_pin.last, got_pin.last);
      end
      pins_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pin states still due",
               cycle_count, pin_states_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Field extremes, every op, both cursor lines, power-up with zero and
  // nonzero held lines, and back-to-back power-up runs.
  task automatic test_directed();
    send_request(lcdnw_pkg::OP_INIT,   8'h00, 4'd0,  1'b0);  // held lines still zero
    send_request(lcdnw_pkg::OP_CMD,    8'h00, 4'd0,  1'b0);
    send_request(lcdnw_pkg::OP_CMD,    8'hFF, 4'd15, 1'b1);
    send_request(lcdnw_pkg::OP_DATA,   8'h00, 4'd0,  1'b0);
    send_request(lcdnw_pkg::OP_DATA,   8'hFF, 4'd15, 1'b1);
    send_request(lcdnw_pkg::OP_DATA,   8'hA5, 4'd5,  1'b0);
    send_request(lcdnw_pkg::OP_DATA,   8'h5A, 4'd10, 1'b1);
    send_request(lcdnw_pkg::OP_CURSOR, 8'h00, 4'd0,  1'b0);
    send_request(lcdnw_pkg::OP_CURSOR, 8'hFF, 4'd15, 1'b0);
    send_request(lcdnw_pkg::OP_CURSOR, 8'h00, 4'd0,  1'b1);
    send_request(lcdnw_pkg::OP_CURSOR, 8'hFF, 4'd15, 1'b1);
    send_request(lcdnw_pkg::OP_DATA,   8'h3C, 4'd0,  1'b0);
    send_request(lcdnw_pkg::OP_INIT,   8'hFF, 4'd15, 1'b1);  // wait state shows low nibble
    send_request(lcdnw_pkg::OP_INIT,   8'h00, 4'd0,  1'b0);  // back to back, nibble from init
    send_request(lcdnw_pkg::OP_CMD,    8'h01, 4'd0,  1'b0);
    send_request(lcdnw_pkg::OP_DATA,   8'h7E, 4'd9,  1'b1);
    drain_pin_states();
  endtask

  task automatic test_random_traffic(int count);
    repeat (count) send_random_request();
    drain_pin_states();
  endtask

  // Burst, full stop until the output is empty, then another burst.
  task automatic test_drain_pause();
    repeat (6) send_random_request();
    drain_pin_states();
    repeat (3) @(negedge clk);
    repeat (6) send_random_request();
    drain_pin_states();
  endtask

  initial begin
    held_nibble    = 4'd0;
    error_count    = 0;
    pins_checked   = 0;
    cycle_count    = 0;
    send_idle_pct  = 32;
    sink_stall_pct = 54;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random_traffic(48);
    test_drain_pause();
    send_idle_pct  = 54;
    sink_stall_pct = 32;
    test_random_traffic(42);
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    test_random_traffic(42);

    // Allow any stray words to surface after the last expected one.
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Checked %0d pin states from %0d command, %0d data, %0d cursor, %0d power-up",
             pins_checked, op_count[lcdnw_pkg::OP_CMD], op_count[lcdnw_pkg::OP_DATA],
             op_count[lcdnw_pkg::OP_CURSOR], op_count[lcdnw_pkg::OP_INIT]);
    $display("requests under sender gaps and sink stalls in both mixes and none; %0d errors",
             error_count);
    if (error_count == 0 && pin_states_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
